FILE: hw/rtl/h2b64_pkg.sv
// ----------------------------------------------------------------------------
// h2b64_pkg
// Shared types, character constants and conversion functions for the
// hex to base64 stream encoder.
// ----------------------------------------------------------------------------
package h2b64_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned MaxRes  = 4;
  localparam int unsigned CntW    = 3;

  localparam logic [CharW-1:0] ChZero   = 8'h30;
  localparam logic [CharW-1:0] ChNine   = 8'h39;
  localparam logic [CharW-1:0] ChUpA    = 8'h41;
  localparam logic [CharW-1:0] ChUpF    = 8'h46;
  localparam logic [CharW-1:0] ChUpZ    = 8'h5A;
  localparam logic [CharW-1:0] ChLowA   = 8'h61;
  localparam logic [CharW-1:0] ChLowF   = 8'h66;
  localparam logic [CharW-1:0] ChPlus   = 8'h2B;
  localparam logic [CharW-1:0] ChSlash  = 8'h2F;
  localparam logic [CharW-1:0] ChPad    = 8'h3D;

  localparam logic [CharW-1:0] OffDigit = 8'd48;
  localparam logic [CharW-1:0] OffUpper = 8'd55;
  localparam logic [CharW-1:0] OffOther = 8'd87;

  typedef struct packed {
    logic [MaxRes-1:0][CharW-1:0] chars;
    logic [CntW-1:0]              cnt;
    logic                         last;
    logic                         bad;
  } res_t;

  function automatic logic [CharW-1:0] digit_value(input logic [CharW-1:0] c);
    logic [CharW-1:0] v;
    if (c >= ChZero && c <= ChNine) begin
      v = c - OffDigit;
    end else if (c >= ChUpA && c <= ChUpZ) begin
      v = c - OffUpper;
    end else begin
      v = c - OffOther;
    end
    return v;
  endfunction

  function automatic logic is_hex(input logic [CharW-1:0] c);
    return (c >= ChZero && c <= ChNine) || (c >= ChUpA && c <= ChUpF) ||
           (c >= ChLowA && c <= ChLowF);
  endfunction

  function automatic logic [CharW-1:0] sextet_char(input logic [5:0] v);
    logic [CharW-1:0] w;
    logic [CharW-1:0] r;
    w = {2'b00, v};
    if (v < 6'd26) begin
      r = ChUpA + w;
    end else if (v < 6'd52) begin
      r = ChLowA + (w - 8'd26);
    end else if (v < 6'd62) begin
      r = ChZero + (w - 8'd52);
    end else if (v == 6'd62) begin
      r = ChPlus;
    end else begin
      r = ChSlash;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/hex_to_base64_stream.sv
// ----------------------------------------------------------------------------
// hex_to_base64_stream
// An accepted hex character is registered in the input stage, and its base64
// characters are registered in the result buffer. Throughput: one character
// per cycle while the receiver is ready and each character yields at most one
// result; more results hold the buffer until sent (up to four at message end).
// Reset clears the message state and empties both the input and result stages.
// ----------------------------------------------------------------------------
module hex_to_base64_stream
  import h2b64_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [CharW-1:0] s_axis_tdata,   // [7:0] hex_char
  input  logic             s_axis_tlast,
  input  logic             s_axis_tuser,   // [0] start_odd
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [CharW-1:0] m_axis_tdata,   // [7:0] b64_char
  output logic             m_axis_tlast,
  output logic             m_axis_tuser    // [0] bad_seen
);

  logic             vld_q, vld_d;
  logic [CharW-1:0] char_q;
  logic             odd_q;
  logic             last_q;
  logic             buf_free;
  logic             take;
  logic             accept;
  res_t             res;

  assign take          = vld_q && buf_free;
  assign s_axis_tready = !vld_q || take;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (take) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= s_axis_tdata;
      odd_q  <= s_axis_tuser;
      last_q <= s_axis_tlast;
    end
  end

  h2b64_encode u_encode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .hex_char_i  (char_q),
    .start_odd_i (odd_q),
    .last_in_i   (last_q),
    .res_o       (res)
  );

  h2b64_serializer u_serializer (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (take),
    .res_i           (res),
    .free_o          (buf_free),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast),
    .m_axis_tuser_o  (m_axis_tuser)
  );

endmodule

FILE: hw/rtl/h2b64_encode.sv
// ----------------------------------------------------------------------------
// h2b64_encode
// Message state and the conversion of one hex character into zero to four
// base64 characters, including the padding flush at the end of a message.
// ----------------------------------------------------------------------------
module h2b64_encode
  import h2b64_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [CharW-1:0] hex_char_i,
  input  logic             start_odd_i,
  input  logic             last_in_i,
  output res_t             res_o
);

  logic [CharW-1:0] high_q, high_d;
  logic             pend_q, pend_d;
  logic [3:0]       carry_q, carry_d;
  logic [1:0]       gpos_q, gpos_d;
  logic             bad_q, bad_d;
  logic             inmsg_q, inmsg_d;

  always_comb begin
    logic [CharW-1:0] d;
    logic [CharW-1:0] b;
    logic             have_byte;
    logic [CntW-1:0]  k;
    res_t             r;

    d         = digit_value(hex_char_i);
    bad_d     = bad_q | ~is_hex(hex_char_i);
    high_d    = high_q;
    pend_d    = pend_q;
    carry_d   = carry_q;
    gpos_d    = gpos_q;
    inmsg_d   = 1'b1;
    have_byte = 1'b0;
    b         = d;
    k         = '0;
    r.chars   = '0;
    r.last    = last_in_i;
    r.bad     = bad_d;

    if (!inmsg_q && start_odd_i) begin
      have_byte = 1'b1;
      b         = d;
    end else if (pend_q) begin
      have_byte = 1'b1;
      b         = {high_q[3:0], 4'b0000} + d;
      pend_d    = 1'b0;
    end else begin
      high_d = d;
      pend_d = 1'b1;
    end

    if (last_in_i && pend_d) begin
      have_byte = 1'b1;
      b         = {high_d[3:0], 4'b0000};
      pend_d    = 1'b0;
    end

    if (have_byte) begin
      case (gpos_q)
        2'd0: begin
          r.chars[0] = sextet_char(b[7:2]);
          k          = 3'd1;
          carry_d    = {2'b00, b[1:0]};
          gpos_d     = 2'd1;
        end
        2'd1: begin
          r.chars[0] = sextet_char({carry_q[1:0], b[7:4]});
          k          = 3'd1;
          carry_d    = b[3:0];
          gpos_d     = 2'd2;
        end
        default: begin
          r.chars[0] = sextet_char({carry_q[3:0], b[7:6]});
          r.chars[1] = sextet_char(b[5:0]);
          k          = 3'd2;
          carry_d    = 4'd0;
          gpos_d     = 2'd0;
        end
      endcase
    end

    if (last_in_i) begin
      case (gpos_d)
        2'd1: begin
          r.chars[k[1:0]]       = sextet_char({carry_d[1:0], 4'b0000});
          r.chars[k[1:0] + 2'd1] = ChPad;
          r.chars[k[1:0] + 2'd2] = ChPad;
          k = k + 3'd3;
        end
        2'd2: begin
          r.chars[k[1:0]]       = sextet_char({carry_d[3:0], 2'b00});
          r.chars[k[1:0] + 2'd1] = ChPad;
          k = k + 3'd2;
        end
        default: begin
        end
      endcase
      high_d  = '0;
      pend_d  = 1'b0;
      carry_d = '0;
      gpos_d  = '0;
      bad_d   = 1'b0;
      inmsg_d = 1'b0;
    end

    r.cnt = k;
    res_o = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_q  <= '0;
      pend_q  <= 1'b0;
      carry_q <= '0;
      gpos_q  <= '0;
      bad_q   <= 1'b0;
      inmsg_q <= 1'b0;
    end else if (take_i) begin
      high_q  <= high_d;
      pend_q  <= pend_d;
      carry_q <= carry_d;
      gpos_q  <= gpos_d;
      bad_q   <= bad_d;
      inmsg_q <= inmsg_d;
    end
  end

endmodule

FILE: hw/rtl/h2b64_serializer.sv
// ----------------------------------------------------------------------------
// h2b64_serializer
// Result buffer that holds the characters produced for one item and hands
// them to the output stream one per transaction.
// ----------------------------------------------------------------------------
module h2b64_serializer
  import h2b64_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  res_t             res_i,
  output logic             free_o,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [CharW-1:0] m_axis_tdata_o,  // [7:0] b64_char
  output logic             m_axis_tlast_o,
  output logic             m_axis_tuser_o   // [0] bad_seen
);

  logic [MaxRes-1:0][CharW-1:0] chars_q, chars_d;
  logic [CntW-1:0]              rem_q, rem_d;
  logic                         last_q, last_d;
  logic                         bad_q, bad_d;
  logic                         pop;

  assign pop    = (rem_q != '0) && m_axis_tready_i;
  assign free_o = (rem_q == '0) || ((rem_q == 3'd1) && m_axis_tready_i);

  always_comb begin
    chars_d = chars_q;
    rem_d   = rem_q;
    last_d  = last_q;
    bad_d   = bad_q;
    if (load_i) begin
      chars_d = res_i.chars;
      rem_d   = res_i.cnt;
      last_d  = res_i.last;
      bad_d   = res_i.bad;
    end else if (pop) begin
      chars_d = {{CharW{1'b0}}, chars_q[MaxRes-1:1]};
      rem_d   = rem_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chars_q <= chars_d;
    last_q  <= last_d;
    bad_q   <= bad_d;
  end

  assign m_axis_tvalid_o = rem_q != '0;
  assign m_axis_tdata_o  = chars_q[0];
  assign m_axis_tlast_o  = last_q && (rem_q == 3'd1);
  assign m_axis_tuser_o  = bad_q;

endmodule

FILE: tb/sv/tb_hex_to_base64_stream.sv
// ----------------------------------------------------------------------------
// tb_hex_to_base64_stream
// Streams hex character messages into the encoder and checks every base64
// character, its end-of-message mark and its non-hex flag against a short
// directed table where it lists them, or else a behavioral encoder kept in the
// bench. Random messages follow under several sender and receiver idle mixes.
// ----------------------------------------------------------------------------
module tb_hex_to_base64_stream;
  timeunit 1ns;
  timeprecision 1ps;
  import h2b64_pkg::*;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
    logic             bad;
  } b64_res_t;

  typedef struct packed {
    logic [CharW-1:0] c;
    logic             odd;
    logic             last;
    logic             typed;
    logic [2:0]       n;
    logic [31:0]      chars;
    logic             bad;
  } hex_row_t;

  localparam int unsigned NumRows = 25;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [CharW-1:0] s_axis_tdata  = '0;
  logic             s_axis_tlast  = 1'b0;
  logic             s_axis_tuser  = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [CharW-1:0] m_axis_tdata;
  logic             m_axis_tlast;
  logic             m_axis_tuser;

  int unsigned snd_idle  = 0;
  int unsigned rcv_stall = 0;
  int unsigned errors    = 0;

  logic [7:0] hi_digit = '0;
  logic       hi_wait  = 1'b0;
  logic [3:0] carry    = '0;
  logic [1:0] grp_pos  = '0;
  logic       msg_bad  = 1'b0;
  logic       msg_open = 1'b0;

  b64_res_t step_out [$];
  b64_res_t b64_q [$];
  hex_row_t dir_rows [NumRows];

  hex_to_base64_stream u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rcv_stall);
  end

  function automatic logic [7:0] b64_symbol(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (w <= 8'd25) return w + 8'd65;
    if (w <= 8'd51) return w + 8'd71;
    if (w <= 8'd61) return w - 8'd4;
    return (w == 8'd62) ? ChPlus : ChSlash;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - 8'd48;
    if (c >= "A" && c <= "Z") return c - 8'd55;
    return c - 8'd87;
  endfunction

  function automatic logic legal_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic [7:0] pick_hex();
    int unsigned k;
    k = $urandom_range(21);
    if (k < 10) return 8'(k) + "0";
    if (k < 16) return 8'(k - 10) + "A";
    return 8'(k - 16) + "a";
  endfunction

  task automatic emit_b64(input logic [7:0] ch);
    step_out.push_back('{ch, 1'b0, msg_bad});
  endtask

  task automatic take_byte(input logic [7:0] b);
    case (grp_pos)
      2'd0: begin
        emit_b64(b64_symbol(b[7:2]));
        carry   = {2'b00, b[1:0]};
        grp_pos = 2'd1;
      end
      2'd1: begin
        emit_b64(b64_symbol({carry[1:0], b[7:4]}));
        carry   = b[3:0];
        grp_pos = 2'd2;
      end
      default: begin
        emit_b64(b64_symbol({carry, b[7:6]}));
        emit_b64(b64_symbol(b[5:0]));
        carry   = '0;
        grp_pos = 2'd0;
      end
    endcase
  endtask

  task automatic encode_hex(input logic [7:0] c, input logic odd, input logic last);
    logic [7:0] d;
    d = hex_digit(c);
    step_out.delete();
    if (!legal_hex(c)) msg_bad = 1'b1;
    if (!msg_open && odd) begin
      take_byte(d);
    end else if (hi_wait) begin
      take_byte({hi_digit[3:0], 4'b0000} + d);
      hi_wait = 1'b0;
    end else begin
      hi_digit = d;
      hi_wait  = 1'b1;
    end
    msg_open = 1'b1;
    if (last) begin
      if (hi_wait) begin
        take_byte({hi_digit[3:0], 4'b0000});
        hi_wait = 1'b0;
      end
      if (grp_pos == 2'd1) begin
        emit_b64(b64_symbol({carry[1:0], 4'b0000}));
        emit_b64(ChPad);
        emit_b64(ChPad);
      end else if (grp_pos == 2'd2) begin
        emit_b64(b64_symbol({carry, 2'b00}));
        emit_b64(ChPad);
      end
      if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
      hi_digit = '0;
      carry    = '0;
      grp_pos  = '0;
      msg_bad  = 1'b0;
      msg_open = 1'b0;
    end
  endtask

  task automatic apply_row(input hex_row_t r);
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= r.c;
    s_axis_tuser  <= r.odd;
    s_axis_tlast  <= r.last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    encode_hex(r.c, r.odd, r.last);
    if (r.typed) begin
      for (int i = 0; i < r.n; i++) begin
        b64_q.push_back('{r.chars[(r.n-1-i)*8 +: 8], r.last && (i == r.n - 1), r.bad});
      end
    end else begin
      foreach (step_out[i]) b64_q.push_back(step_out[i]);
    end
  endtask

  task automatic run_phase(input int unsigned n, input int unsigned idle,
                           input int unsigned stall);
    hex_row_t    r;
    int unsigned sent;
    int unsigned len;
    logic        noisy;
    snd_idle  = idle;
    rcv_stall = stall;
    sent      = 0;
    r         = '0;
    while (sent < n) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
      if (len > n - sent) len = n - sent;
      noisy = ($urandom_range(99) < 15);
      for (int unsigned i = 0; i < len; i++) begin
        if (noisy || $urandom_range(99) < 4) r.c = 8'($urandom_range(255));
        else r.c = pick_hex();
        if (noisy) r.odd = 1'($urandom_range(1));
        else if (i == 0) r.odd = (len % 2 == 1) && ($urandom_range(99) < 80);
        else r.odd = 1'b0;
        r.last = (i == len - 1);
        apply_row(r);
        sent++;
      end
    end
  endtask

  task automatic report_err(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    b64_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (b64_q.size() == 0) begin
        report_err("unexpected transaction", m_axis_tdata, 8'h00);
      end else begin
        want = b64_q.pop_front();
        if (m_axis_tdata !== want.ch) report_err("b64_char", m_axis_tdata, want.ch);
        if (m_axis_tlast !== want.last) begin
          report_err("last_out", {7'b0, m_axis_tlast}, {7'b0, want.last});
        end
        if (m_axis_tuser !== want.bad) begin
          report_err("bad_seen", {7'b0, m_axis_tuser}, {7'b0, want.bad});
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("tb_hex_to_base64_stream: errors");
    $finish;
  end

  initial begin
    dir_rows = '{
      '{"0",   1'b1, 1'b1, 1'b1, 3'd4, "AA==",          1'b0},
      '{"F",   1'b0, 1'b0, 1'b1, 3'd0, 32'h0,           1'b0},
      '{"F",   1'b0, 1'b0, 1'b1, 3'd1, {24'h0, "/"},    1'b0},
      '{"f",   1'b0, 1'b0, 1'b1, 3'd0, 32'h0,           1'b0},
      '{"f",   1'b0, 1'b0, 1'b1, 3'd1, {24'h0, "/"},    1'b0},
      '{"F",   1'b0, 1'b0, 1'b1, 3'd0, 32'h0,           1'b0},
      '{"F",   1'b0, 1'b1, 1'b1, 3'd2, {16'h0, "//"},   1'b0},
      '{8'h00, 1'b1, 1'b1, 1'b0, 3'd0, 32'h0,           1'b0},
      '{8'hFF, 1'b0, 1'b0, 1'b0, 3'd0, 32'h0,           1'b0},
      '{8'hFF, 1'b0, 1'b1, 1'b0, 3'd0, 32'h0,           1'b0},
      '{"A",   1'b0, 1'b1, 1'b0, 3'd0, 32'h0,           1'b0},
      '{"1",   1'b1, 1'b0, 1'b0, 3'd0, 32'h0,           1'b0},
      '{"2",   1'b1, 1'b0, 1'b0, 3'd0, 32'h0,           1'b0},
      '{"3",   1'b1, 1'b1, 1'b0, 3'd0, 32'h0,           1'b0},
      '{"Z",   1'b0, 1'b0, 1'b0, 3'd0, 32'h0,           1'b0},
      '{"g",   1'b0, 1'b1, 1'b0, 3'd0, 32'h0,           1'b0},
      '{"9",   1'b1, 1'b1, 1'b0, 3'd0, 32'h0,           1'b0},
      '{"0",   1'b0, 1'b0, 1'b0, 3'd0, 32'h0,           1'b0},
      '{"1",   1'b0, 1'b0, 1'b0, 3'd0, 32'h0,           1'b0},
      '{"2",   1'b0, 1'b0, 1'b0, 3'd0, 32'h0,           1'b0},
      '{"3",   1'b0, 1'b0, 1'b0, 3'd0, 32'h0,           1'b0},
      '{"a",   1'b0, 1'b0, 1'b0, 3'd0, 32'h0,           1'b0},
      '{"b",   1'b0, 1'b0, 1'b0, 3'd0, 32'h0,           1'b0},
      '{"C",   1'b0, 1'b0, 1'b0, 3'd0, 32'h0,           1'b0},
      '{"D",   1'b0, 1'b1, 1'b0, 3'd0, 32'h0,           1'b0}
    };
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (dir_rows[i]) apply_row(dir_rows[i]);
    run_phase(80, 0, 0);
    run_phase(80, 62, 0);
    run_phase(80, 0, 62);
    run_phase(80, 20, 20);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (b64_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_hex_to_base64_stream: clean");
    end else begin
      $display("tb_hex_to_base64_stream: errors");
    end
    $finish;
  end

endmodule
